### sv/edd_pkg.sv
package edd_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int PIXEL_BITS_DEF = 16;

    localparam int PIX_W          = 16;
    localparam int LEVEL_W        = 16;
    localparam int SCALE_SHIFT    = 8;
    localparam int LEVEL_SCALED_W = LEVEL_W + SCALE_SHIFT;
    localparam int ERR_W          = 27;
    localparam int WIDE_W         = 32;
    localparam int ROW_WIDTH_W    = 11;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 16;
    localparam int TDATA_IN_W     = 16;
    localparam int TDATA_OUT_W    = 8;

    localparam logic [CFG_IDX_W-1:0] REG_BLACK     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WHITE     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CLAMP     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH = 2'd3;

    localparam logic [LEVEL_W-1:0]     BLACK_RST     = 16'd0;
    localparam logic [LEVEL_W-1:0]     WHITE_RST     = 16'd255;
    localparam logic [ROW_WIDTH_W-1:0] ROW_WIDTH_RST = 11'd640;

    typedef logic signed [ERR_W-1:0]  err_t;
    typedef logic signed [WIDE_W-1:0] wide_t;

    localparam wide_t ERR_MAX     = wide_t'((64'sd1 <<< (ERR_W - 1)) - 64'sd1);
    localparam wide_t ERR_MIN     = -ERR_MAX - wide_t'(1);
    localparam wide_t SHARE_ROUND = wide_t'(8);
    localparam int    SHARE_SHIFT = 4;

    localparam logic [3:0] W_RIGHT      = 4'd7;
    localparam logic [3:0] W_BELOW_LEFT = 4'd3;
    localparam logic [3:0] W_BELOW      = 4'd5;
    localparam logic [3:0] W_BELOW_RGT  = 4'd1;

    // per-item control carried with the item into the diffusion stage
    typedef struct packed {
        logic frame_start;
        logic first_row;
        logic last;
        logic has_left;
    } edd_ctrl_t;

    function automatic err_t sat_err(input wide_t v);
        err_t r;
        if (v > ERR_MAX) begin
            r = err_t'(ERR_MAX);
        end else if (v < ERR_MIN) begin
            r = err_t'(ERR_MIN);
        end else begin
            r = err_t'(v);
        end
        return r;
    endfunction

    // floor((k * e + 8) / 16)
    function automatic wide_t share(input logic [3:0] k, input wide_t e);
        wide_t t;
        t = e * wide_t'(k) + SHARE_ROUND;
        return t >>> SHARE_SHIFT;
    endfunction

endpackage

### sv/error_diffusion_dither.sv
// An item accepted into stage 1 moves on into the output register that drives m_tvalid
// once that register is free or drains, so a stalled output side holds it in stage 1.
// Throughput: one item per clock unless the output stalls; the error loop (line memory
// read, correction, threshold, share of the right neighbor) closes in a single stage.
// Reset (aresetn low, synchronous): registers return to their reset values and the
// position returns to the first row; the error line memory is not cleared.
module error_diffusion_dither #(
    parameter int MAX_WIDTH  = edd_pkg::MAX_WIDTH_DEF,
    parameter int PIXEL_BITS = edd_pkg::PIXEL_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // input items
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [edd_pkg::TDATA_IN_W-1:0]      s_tdata,   // [15:0] pixel_value
    input  logic [0:0]                          s_tuser,   // [0] frame_start
    // result items
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [edd_pkg::TDATA_OUT_W-1:0]     m_tdata,   // [0] dot, [7:1] zero
    output logic                                m_tlast,   // row_end
    // configuration writes
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [edd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [edd_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import edd_pkg::*;

    localparam int AW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int CLG_W = $clog2(MAX_WIDTH + 1);
    localparam int CW    = (ROW_WIDTH_W > CLG_W) ? ROW_WIDTH_W : CLG_W;

    // configuration registers
    logic [LEVEL_W-1:0]     black_reg, white_reg;
    logic                   clamp_reg;
    logic [ROW_WIDTH_W-1:0] width_reg;

    logic [LEVEL_SCALED_W-1:0] lo, hi, mid;
    logic [LEVEL_SCALED_W:0]   lo_hi_sum;

    // position tracking
    logic [AW-1:0] col_reg, col_next;
    logic          first_reg, first_next;

    // stage 1
    logic                      s1_v_reg;
    edd_ctrl_t                 s1_ctrl_reg;
    logic [AW-1:0]             s1_x_reg;
    logic [LEVEL_SCALED_W-1:0] s1_scaled_reg;
    logic                      hit_reg, hit_next;
    err_t                      hit_data_reg;

    // deferred write of the entry under the last pixel of a row
    logic          pend_v_reg;
    logic [AW-1:0] pend_addr_reg;
    err_t          pend_data_reg;

    // output register
    logic o_v_reg, o_dot_reg, o_last_reg;

    logic accept, adv;
    logic [CW-1:0] w_raw, w_eff, x_ext;
    logic [AW-1:0] col_base, in_x;
    logic          in_fs, in_first, in_last;
    edd_ctrl_t     in_ctrl;
    logic [PIX_W-1:0]          pix;
    logic [LEVEL_SCALED_W-1:0] scaled_raw, scaled_clamped;

    logic          wr_en, wr_hit;
    logic [AW-1:0] wr_addr;
    err_t          wr_data, rd_data, line_sel;
    logic          dot;
    err_t          left_err, here_err;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            black_reg <= BLACK_RST;
            white_reg <= WHITE_RST;
            clamp_reg <= 1'b0;
            width_reg <= ROW_WIDTH_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_BLACK:     black_reg <= cfg_data[LEVEL_W-1:0];
                REG_WHITE:     white_reg <= cfg_data[LEVEL_W-1:0];
                REG_CLAMP:     clamp_reg <= cfg_data[0];
                REG_ROW_WIDTH: width_reg <= cfg_data[ROW_WIDTH_W-1:0];
                default: ;
            endcase
        end
    end

    assign lo        = {black_reg, SCALE_SHIFT'(0)};
    assign hi        = {white_reg, SCALE_SHIFT'(0)};
    assign lo_hi_sum = (LEVEL_SCALED_W + 1)'(lo) + (LEVEL_SCALED_W + 1)'(hi);
    assign mid       = lo_hi_sum[LEVEL_SCALED_W:1];

    // handshake: stage 1 moves on whenever the output register is free or drains
    assign adv      = s1_v_reg && (!o_v_reg || m_tready);
    assign s_tready = !s1_v_reg || adv;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        in_fs = s_tuser[0];

        w_raw = CW'(width_reg);
        if (w_raw == '0) begin
            w_eff = CW'(1);
        end else if (w_raw > CW'(MAX_WIDTH)) begin
            w_eff = CW'(MAX_WIDTH);
        end else begin
            w_eff = w_raw;
        end

        col_base = in_fs ? '0 : col_reg;
        x_ext    = CW'(col_base);
        if (x_ext >= w_eff) begin
            x_ext = w_eff - CW'(1);
        end
        in_x     = x_ext[AW-1:0];
        in_last  = (x_ext + CW'(1)) >= w_eff;
        in_first = in_fs || first_reg;

        in_ctrl.frame_start = in_fs;
        in_ctrl.first_row   = in_first;
        in_ctrl.last        = in_last;
        in_ctrl.has_left    = (in_x != '0);

        col_next   = col_reg;
        first_next = first_reg;
        if (accept) begin
            col_next   = in_last ? '0 : in_x + AW'(1);
            first_next = in_last ? 1'b0 : in_first;
        end

        pix        = PIX_W'(s_tdata[PIXEL_BITS-1:0]);
        scaled_raw = {pix, SCALE_SHIFT'(0)};
        scaled_clamped = scaled_raw;
        if (clamp_reg) begin
            if (scaled_clamped > hi) begin
                scaled_clamped = hi;
            end
            if (scaled_clamped < lo) begin
                scaled_clamped = lo;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg   <= '0;
            first_reg <= 1'b1;
        end else begin
            col_reg   <= col_next;
            first_reg <= first_next;
        end
    end

    // one write port: the deferred entry goes out the cycle after a row's last pixel,
    // when stage 1 holds nothing or a column 0 pixel that writes nothing
    always_comb begin
        if (pend_v_reg) begin
            wr_en   = 1'b1;
            wr_addr = pend_addr_reg;
            wr_data = pend_data_reg;
        end else begin
            wr_en   = adv && s1_ctrl_reg.has_left;
            wr_addr = s1_x_reg - AW'(1);
            wr_data = left_err;
        end
        // patch the read data with writes that land after the read was issued
        wr_hit   = wr_en && (wr_addr == (accept ? in_x : s1_x_reg));
        hit_next = wr_hit || (hit_reg && !accept);
    end

    edd_line_mem #(
        .DEPTH (MAX_WIDTH),
        .AW    (AW)
    ) u_line_mem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (accept),
        .rd_addr (in_x),
        .rd_data (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_v_reg   <= 1'b0;
            hit_reg    <= 1'b0;
            pend_v_reg <= 1'b0;
            o_v_reg    <= 1'b0;
        end else begin
            if (accept) begin
                s1_v_reg <= 1'b1;
            end else if (adv) begin
                s1_v_reg <= 1'b0;
            end
            hit_reg    <= hit_next;
            pend_v_reg <= adv && s1_ctrl_reg.last;
            if (adv) begin
                o_v_reg <= 1'b1;
            end else if (m_tready) begin
                o_v_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_ctrl_reg   <= in_ctrl;
            s1_x_reg      <= in_x;
            s1_scaled_reg <= scaled_clamped;
        end
        if (wr_hit) begin
            hit_data_reg <= wr_data;
        end
        if (adv) begin
            pend_addr_reg <= s1_x_reg;
            pend_data_reg <= here_err;
            o_dot_reg     <= dot;
            o_last_reg    <= s1_ctrl_reg.last;
        end
    end

    always_comb begin
        if (pend_v_reg && (pend_addr_reg == s1_x_reg)) begin
            line_sel = pend_data_reg;
        end else if (hit_reg) begin
            line_sel = hit_data_reg;
        end else begin
            line_sel = rd_data;
        end
    end

    edd_diffuse u_diffuse (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (adv),
        .ctrl     (s1_ctrl_reg),
        .scaled   (s1_scaled_reg),
        .lo       (lo),
        .hi       (hi),
        .mid      (mid),
        .line     (line_sel),
        .dot      (dot),
        .left_err (left_err),
        .here_err (here_err)
    );

    assign m_tvalid = o_v_reg;
    assign m_tdata  = {(TDATA_OUT_W - 1)'(0), o_dot_reg};
    assign m_tlast  = o_last_reg;

endmodule

### sv/edd_line_mem.sv
module edd_line_mem #(
    parameter int DEPTH = edd_pkg::MAX_WIDTH_DEF,
    parameter int AW    = $clog2(edd_pkg::MAX_WIDTH_DEF)
) (
    input  logic                aclk,
    input  logic                wr_en,
    input  logic [AW-1:0]       wr_addr,
    input  edd_pkg::err_t       wr_data,
    input  logic                rd_en,
    input  logic [AW-1:0]       rd_addr,
    output edd_pkg::err_t       rd_data
);
    import edd_pkg::*;

    err_t mem [DEPTH];
    err_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### sv/edd_diffuse.sv
module edd_diffuse (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    en,
    input  edd_pkg::edd_ctrl_t                      ctrl,
    input  logic [edd_pkg::LEVEL_SCALED_W-1:0]      scaled,
    input  logic [edd_pkg::LEVEL_SCALED_W-1:0]      lo,
    input  logic [edd_pkg::LEVEL_SCALED_W-1:0]      hi,
    input  logic [edd_pkg::LEVEL_SCALED_W-1:0]      mid,
    input  edd_pkg::err_t                           line,
    output logic                                    dot,
    output edd_pkg::err_t                           left_err,
    output edd_pkg::err_t                           here_err
);
    import edd_pkg::*;

    err_t  rc_reg, rc_next;
    err_t  bl_reg, bl_next;
    err_t  bh_reg, bh_next;
    wide_t rc_eff, bl_eff, bh_eff, line_eff;
    wide_t sum, err;
    wide_t s7, s3, s5, s1;
    err_t  val;

    always_comb begin
        // a frame start drops whatever the previous frame left pending
        rc_eff   = ctrl.frame_start ? '0 : wide_t'(rc_reg);
        bl_eff   = ctrl.frame_start ? '0 : wide_t'(bl_reg);
        bh_eff   = ctrl.frame_start ? '0 : wide_t'(bh_reg);
        line_eff = ctrl.first_row   ? '0 : wide_t'(line);

        sum = wide_t'(scaled) + line_eff + rc_eff;
        val = sat_err(sum);
        dot = wide_t'(val) > wide_t'(mid);
        err = wide_t'(val) - (dot ? wide_t'(hi) : wide_t'(lo));

        s7 = share(W_RIGHT, err);
        s3 = share(W_BELOW_LEFT, err);
        s5 = share(W_BELOW, err);
        s1 = share(W_BELOW_RGT, err);

        left_err = sat_err(bl_eff + s3);
        here_err = sat_err(bh_eff + s5);

        rc_next = rc_reg;
        bl_next = bl_reg;
        bh_next = bh_reg;
        if (en) begin
            if (ctrl.last) begin
                rc_next = '0;
                bl_next = '0;
                bh_next = '0;
            end else begin
                bl_next = here_err;
                bh_next = sat_err(s1);
                rc_next = sat_err(s7);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rc_reg <= '0;
            bl_reg <= '0;
            bh_reg <= '0;
        end else begin
            rc_reg <= rc_next;
            bl_reg <= bl_next;
            bh_reg <= bh_next;
        end
    end

endmodule

### dv/tb_error_diffusion_dither.sv
`timescale 1ns / 100ps

module tb_error_diffusion_dither;
    import edd_pkg::*;

    localparam int CYCLE_LIMIT = 800000;
    localparam int LONG_HOLD   = 300;
    localparam int TAIL_CYCLES = 16;
    localparam int LINE_DEPTH  = MAX_WIDTH_DEF;
    localparam longint ERR_HI  = 64'sd67108863;
    localparam longint ERR_LO  = -64'sd67108864;

    typedef struct packed {
        logic dot;
        logic row_end;
    } dot_result_t;

    logic                   aclk;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [TDATA_IN_W-1:0]  s_tdata   = '0;
    logic [0:0]             s_tuser   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [TDATA_OUT_W-1:0] m_tdata;
    logic                   m_tlast;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    // register shadows
    logic [LEVEL_W-1:0]     lvl_black     = BLACK_RST;
    logic [LEVEL_W-1:0]     lvl_white     = WHITE_RST;
    logic                   clamp_on      = 1'b0;
    logic [ROW_WIDTH_W-1:0] row_width_reg = ROW_WIDTH_RST;

    // diffusion state of the predictor
    longint      line_err [LINE_DEPTH];
    longint      carry_right    = 0;
    longint      sum_below_left = 0;
    longint      sum_below_here = 0;
    int unsigned cur_col        = 0;
    bit          on_first_row   = 1'b1;

    dot_result_t dots_pending [$];

    bit          src_idle_on  = 1'b1;
    bit          sink_idle_on = 1'b1;
    bit          sink_hold    = 1'b0;
    int unsigned sink_wait    = 0;
    event        long_hold_ev;

    int mismatch_count = 0;
    int result_count   = 0;
    int items_sent     = 0;
    int cfg_writes     = 0;
    int frames_started = 0;
    int row_ends       = 0;
    int sat_hits       = 0;
    int input_stalls   = 0;
    int cycle_count    = 0;

    error_diffusion_dither i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic longint clip_err(input longint v);
        if (v > ERR_HI) begin
            sat_hits++;
            return ERR_HI;
        end
        if (v < ERR_LO) begin
            sat_hits++;
            return ERR_LO;
        end
        return v;
    endfunction

    // floor((k * e + 8) / 16)
    function automatic longint diffuse_share(input longint k, input longint e);
        return (k * e + 64'sd8) >>> 4;
    endfunction

    function automatic dot_result_t predict_dot(input logic [PIX_W-1:0] pix, input logic fs);
        longint      lo, hi, mid, val, err, s3, s5;
        int unsigned w, x;
        bit          last;
        dot_result_t r;
        lo  = longint'(lvl_black) * 256;
        hi  = longint'(lvl_white) * 256;
        mid = (lo + hi) / 2;
        if (fs) begin
            carry_right    = 0;
            sum_below_left = 0;
            sum_below_here = 0;
            cur_col        = 0;
            on_first_row   = 1'b1;
        end
        w = 32'(row_width_reg);
        if (w < 1) w = 1;
        if (w > LINE_DEPTH) w = LINE_DEPTH;
        // a column left past a shrunken width acts as the last one
        x = (cur_col >= w) ? w - 1 : cur_col;
        last = (x + 1 >= w);
        val = longint'(pix) * 256;
        if (clamp_on) begin
            if (val > hi) val = hi;
            if (val < lo) val = lo;
        end
        if (!on_first_row) val += line_err[x];
        val = clip_err(val + carry_right);
        if (val <= mid) begin
            r.dot = 1'b0;
            err   = val - lo;
        end else begin
            r.dot = 1'b1;
            err   = val - hi;
        end
        s3 = diffuse_share(3, err);
        s5 = diffuse_share(5, err);
        if (x > 0) line_err[x - 1] = clip_err(sum_below_left + s3);
        if (last) begin
            line_err[x]    = clip_err(sum_below_here + s5);
            carry_right    = 0;
            sum_below_left = 0;
            sum_below_here = 0;
            cur_col        = 0;
            on_first_row   = 1'b0;
        end else begin
            sum_below_left = clip_err(sum_below_here + s5);
            sum_below_here = clip_err(diffuse_share(1, err));
            carry_right    = clip_err(diffuse_share(7, err));
            cur_col        = x + 1;
        end
        r.row_end = last;
        return r;
    endfunction

    // mostly back to back, some short gaps, a few long ones
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [PIX_W-1:0] pick_pixel();
        case ($urandom_range(0, 9))
            0: return 16'h0000;
            1: return 16'hffff;
            2, 3: return lvl_black + 16'($urandom_range(0, 6)) - 16'd3;
            4, 5: return lvl_white + 16'($urandom_range(0, 6)) - 16'd3;
            default: return 16'($urandom());
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        if (mismatch_count < 40)
            $display("MISMATCH at %0t, result %0d, %s: got %h expected %h",
                     $time, result_count, what, got, want);
        mismatch_count++;
    endtask

    task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic fs);
        int unsigned gap;
        dot_result_t want;
        gap = src_idle_on ? pick_gap() : 0;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pix;
        s_tuser  <= fs;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        want = predict_dot(pix, fs);
        dots_pending.push_back(want);
        items_sent++;
        if (fs) frames_started++;
        if (want.row_end) row_ends++;
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (dots_pending.size() != 0) @(negedge aclk);
    endtask

    task automatic configure(input logic [CFG_DATA_W-1:0] black, input logic [CFG_DATA_W-1:0] white,
                             input logic [CFG_DATA_W-1:0] clamp_word,
                             input logic [CFG_DATA_W-1:0] width_word);
        logic [CFG_IDX_W-1:0]  regs [4];
        logic [CFG_DATA_W-1:0] vals [4];
        regs = '{REG_BLACK, REG_WHITE, REG_CLAMP, REG_ROW_WIDTH};
        vals = '{black, white, clamp_word, width_word};
        for (int i = 0; i < 4; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= regs[i];
            cfg_data  <= vals[i];
            @(posedge aclk);
            while (!cfg_ready) @(posedge aclk);
            case (regs[i])
                REG_BLACK: lvl_black = vals[i];
                REG_WHITE: lvl_white = vals[i];
                REG_CLAMP: clamp_on = vals[i][0];
                default: row_width_reg = vals[i][ROW_WIDTH_W-1:0];
            endcase
            cfg_writes++;
            @(negedge aclk);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic test_reset_values();
        send_pixel(16'h00ff, 1'b1);
        send_pixel(16'h0080, 1'b0);
    endtask

    task automatic test_pixel_extremes();
        wait_drained();
        configure(16'h0000, 16'hffff, 16'h0000, 16'd2);
        send_pixel(16'h0000, 1'b1);
        send_pixel(16'hffff, 1'b0);
        send_pixel(16'h8000, 1'b0);
        send_pixel(16'h7fff, 1'b0);
        // new frame on a row that already carries error from above
        send_pixel(16'haaaa, 1'b1);
        send_pixel(16'h5555, 1'b0);
        send_pixel(16'h1234, 1'b0);
        // new frame in the middle of a row
        send_pixel(16'hedcb, 1'b1);
    endtask

    task automatic test_width_limits();
        wait_drained();
        // zero width acts as one; the column left at 1 counts as the last
        configure(16'h0000, 16'hffff, 16'h0000, {5'($urandom()), 11'd0});
        send_pixel(16'h9000, 1'b0);
        send_pixel(16'h3000, 1'b0);
        wait_drained();
        configure(16'h0000, 16'hffff, 16'h0000, 16'd1);
        send_pixel(16'hc000, 1'b0);
        send_pixel(16'h4000, 1'b0);
    endtask

    task automatic test_clamp();
        wait_drained();
        configure(16'h1000, 16'h3000, {15'($urandom()), 1'b1}, 16'd3);
        send_pixel(16'h0000, 1'b1);
        send_pixel(16'hffff, 1'b0);
        send_pixel(16'h2000, 1'b0);
        wait_drained();
        // crossed levels: the floor is applied last and wins
        configure(16'hff00, 16'h0100, 16'h0001, 16'd3);
        send_pixel(16'h0000, 1'b0);
        send_pixel(16'hffff, 1'b0);
    endtask

    task automatic test_saturation();
        wait_drained();
        // crossed levels without clamping let the error run away both ways
        configure(16'hffff, 16'h0000, 16'h0000, 16'd2);
        send_pixel(16'hffff, 1'b1);
        repeat (4) send_pixel(16'hffff, 1'b0);
        send_pixel(16'h0000, 1'b1);
        repeat (4) send_pixel(16'h0000, 1'b0);
    endtask

    // one full row at the widest setting writes every line entry, so later
    // rows of any width only read entries that hold an error
    task automatic test_full_width_row();
        wait_drained();
        configure(16'h0000, 16'($urandom_range(1, 65535)),
                  {15'($urandom()), 1'($urandom_range(0, 1))}, {5'($urandom()), 11'd2047});
        src_idle_on = 1'b0;
        -> long_hold_ev;
        send_pixel(pick_pixel(), 1'b1);
        for (int k = 1; k < LINE_DEPTH + 16; k++) begin
            if (k == 150) src_idle_on = 1'b1;
            send_pixel(pick_pixel(), 1'b0);
        end
    endtask

    task automatic test_drain_pause();
        wait_drained();
        configure(16'h0000, 16'h00ff, 16'h0000, 16'd5);
        repeat (20) send_pixel(pick_pixel(), 1'b0);
        wait_drained();
        repeat (20) send_pixel(pick_pixel(), 1'b0);
    endtask

    task automatic test_random_phases();
        logic [15:0]            a, b, blk, wht;
        logic [ROW_WIDTH_W-1:0] w;
        int unsigned            r, n;
        bit                     new_frame;
        for (int p = 0; p < 22; p++) begin
            wait_drained();
            a = 16'($urandom());
            b = 16'($urandom());
            case ($urandom_range(0, 5))
                0: begin blk = 16'h0000; wht = 16'hffff; end
                1: begin blk = a; wht = b; end
                2: begin blk = (a < b) ? a : b; wht = (a < b) ? b : a; end
                3: begin blk = (a < b) ? b : a; wht = (a < b) ? a : b; end
                4: begin blk = {16{a[0]}}; wht = blk; end
                default: begin blk = 16'h0000; wht = 16'h00ff; end
            endcase
            r = $urandom_range(0, 19);
            if (r < 3) w = 11'(r);
            else if (r == 3) w = 11'($urandom_range(LINE_DEPTH + 1, 2047));
            else if (r < 15) w = 11'($urandom_range(3, 16));
            else w = 11'($urandom_range(17, 120));
            configure(blk, wht, {15'($urandom()), 1'($urandom_range(0, 1))},
                      {5'($urandom()), w});
            src_idle_on  = ($urandom_range(0, 3) != 0);
            sink_idle_on = ($urandom_range(0, 3) != 0);
            if (p == 9) -> long_hold_ev;
            new_frame = 1'($urandom_range(0, 1));
            n = $urandom_range(28, 40);
            for (int k = 0; k < n; k++)
                send_pixel(pick_pixel(), (k == 0 && new_frame) || ($urandom_range(0, 59) == 0));
        end
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
    endtask

    // receiver side: random gaps, or a long hold-off on request
    always @(negedge aclk) begin
        if (sink_hold) begin
            m_tready <= 1'b0;
        end else if (sink_wait != 0) begin
            m_tready  <= 1'b0;
            sink_wait <= sink_wait - 1;
        end else begin
            m_tready <= 1'b1;
            if (sink_idle_on) sink_wait <= pick_gap();
        end
    end

    initial begin : long_hold
        forever begin
            @(long_hold_ev);
            sink_hold = 1'b1;
            repeat (LONG_HOLD) @(posedge aclk);
            sink_hold = 1'b0;
        end
    end

    always @(posedge aclk) begin : result_check
        dot_result_t want;
        if (aresetn && s_tvalid && !s_tready) input_stalls++;
        if (aresetn && m_tvalid && m_tready) begin
            result_count++;
            if (dots_pending.size() == 0) begin
                report_mismatch("result with no pixel pending", {m_tlast, m_tdata[6:0]}, 8'h00);
            end else begin
                want = dots_pending.pop_front();
                if (m_tdata[0] !== want.dot)
                    report_mismatch("dot", 8'(m_tdata[0]), 8'(want.dot));
                if (m_tlast !== want.row_end)
                    report_mismatch("row_end", 8'(m_tlast), 8'(want.row_end));
                if (m_tdata[TDATA_OUT_W-1:1] !== '0)
                    report_mismatch("tdata padding", 8'(m_tdata), 8'h00);
            end
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycle_count, dots_pending.size());
        $display("tb: failure");
        $finish;
    end

    initial begin : run_tests
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_values();
        test_pixel_extremes();
        test_width_limits();
        test_clamp();
        test_saturation();
        test_full_width_row();
        test_drain_pause();
        test_random_phases();

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (dots_pending.size() != 0)
            report_mismatch("results never delivered", 8'(dots_pending.size()), 8'h00);

        $display("covered %0d pixels, %0d dots, %0d register writes, %0d frame starts, %0d row ends",
                 items_sent, result_count, cfg_writes, frames_started, row_ends);
        $display("covered %0d saturated error sums, %0d cycles with the input held off",
                 sat_hits, input_stalls);
        if (mismatch_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
